>>> rtl/core/sbt_pkg.sv
`timescale 1ns / 1ps

package sbt_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_OP   = 2'd3
  } mode_t;

  localparam logic [5:0] K_END      = 6'd0;
  localparam logic [5:0] K_NAME     = 6'd1;
  localparam logic [5:0] K_INT      = 6'd2;
  localparam logic [5:0] K_FN       = 6'd3;
  localparam logic [5:0] K_LPAREN   = 6'd4;
  localparam logic [5:0] K_RPAREN   = 6'd5;
  localparam logic [5:0] K_LBRACE   = 6'd6;
  localparam logic [5:0] K_RBRACE   = 6'd7;
  localparam logic [5:0] K_LBRACKET = 6'd8;
  localparam logic [5:0] K_RBRACKET = 6'd9;
  localparam logic [5:0] K_ADD      = 6'd10;
  localparam logic [5:0] K_ADD_EQ   = 6'd11;
  localparam logic [5:0] K_SUB      = 6'd12;
  localparam logic [5:0] K_SUB_EQ   = 6'd13;
  localparam logic [5:0] K_MUL      = 6'd14;
  localparam logic [5:0] K_MUL_EQ   = 6'd15;
  localparam logic [5:0] K_DIV      = 6'd16;
  localparam logic [5:0] K_DIV_EQ   = 6'd17;
  localparam logic [5:0] K_MOD      = 6'd18;
  localparam logic [5:0] K_MOD_EQ   = 6'd19;
  localparam logic [5:0] K_ASSIGN   = 6'd20;
  localparam logic [5:0] K_EQ       = 6'd21;
  localparam logic [5:0] K_AND      = 6'd22;
  localparam logic [5:0] K_LAND     = 6'd23;
  localparam logic [5:0] K_AND_EQ   = 6'd24;
  localparam logic [5:0] K_OR       = 6'd25;
  localparam logic [5:0] K_LOR      = 6'd26;
  localparam logic [5:0] K_OR_EQ    = 6'd27;
  localparam logic [5:0] K_XOR      = 6'd28;
  localparam logic [5:0] K_XOR_EQ   = 6'd29;
  localparam logic [5:0] K_NOT      = 6'd30;
  localparam logic [5:0] K_LT       = 6'd31;
  localparam logic [5:0] K_SHL      = 6'd32;
  localparam logic [5:0] K_SHL_EQ   = 6'd33;
  localparam logic [5:0] K_LE       = 6'd34;
  localparam logic [5:0] K_GT       = 6'd35;
  localparam logic [5:0] K_SHR      = 6'd36;
  localparam logic [5:0] K_SHR_EQ   = 6'd37;
  localparam logic [5:0] K_GE       = 6'd38;
  localparam logic [5:0] K_NE       = 6'd39;
  localparam logic [5:0] K_LNOT     = 6'd40;
  localparam logic [5:0] K_ERROR    = 6'd41;

  localparam logic [3:0] P_NONE   = 4'd0;
  localparam logic [3:0] P_ADD    = 4'd1;
  localparam logic [3:0] P_SUB    = 4'd2;
  localparam logic [3:0] P_MUL    = 4'd3;
  localparam logic [3:0] P_DIV    = 4'd4;
  localparam logic [3:0] P_MOD    = 4'd5;
  localparam logic [3:0] P_ASSIGN = 4'd6;
  localparam logic [3:0] P_AND    = 4'd7;
  localparam logic [3:0] P_OR     = 4'd8;
  localparam logic [3:0] P_XOR    = 4'd9;
  localparam logic [3:0] P_LT     = 4'd10;
  localparam logic [3:0] P_SHL    = 4'd11;
  localparam logic [3:0] P_GT     = 4'd12;
  localparam logic [3:0] P_SHR    = 4'd13;
  localparam logic [3:0] P_LNOT   = 4'd14;

  localparam logic [7:0] CHAR_F        = 8'h66;
  localparam logic [7:0] CHAR_N        = 8'h6E;
  localparam logic [7:0] HIGH_BIT_MASK = 8'h80;

  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
  localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } result_t;

  function automatic logic [5:0] alone_kind(input logic [3:0] p);
    logic [5:0] k;
    case (p)
      P_ADD:    k = K_ADD;
      P_SUB:    k = K_SUB;
      P_MUL:    k = K_MUL;
      P_DIV:    k = K_DIV;
      P_MOD:    k = K_MOD;
      P_ASSIGN: k = K_ASSIGN;
      P_AND:    k = K_AND;
      P_OR:     k = K_OR;
      P_XOR:    k = K_XOR;
      P_LT:     k = K_LT;
      P_SHL:    k = K_SHL;
      P_GT:     k = K_GT;
      P_SHR:    k = K_SHR;
      P_LNOT:   k = K_LNOT;
      default:  k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] eq_kind(input logic [3:0] p);
    logic [5:0] k;
    case (p)
      P_ADD:    k = K_ADD_EQ;
      P_SUB:    k = K_SUB_EQ;
      P_MUL:    k = K_MUL_EQ;
      P_DIV:    k = K_DIV_EQ;
      P_MOD:    k = K_MOD_EQ;
      P_ASSIGN: k = K_EQ;
      P_AND:    k = K_AND_EQ;
      P_OR:     k = K_OR_EQ;
      P_XOR:    k = K_XOR_EQ;
      P_LT:     k = K_LE;
      P_SHL:    k = K_SHL_EQ;
      P_GT:     k = K_GE;
      P_SHR:    k = K_SHR_EQ;
      P_LNOT:   k = K_NE;
      default:  k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic is_word_byte(input logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"]}) || ((c & HIGH_BIT_MASK) != 8'h00);
  endfunction

  function automatic logic is_digit_byte(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

endpackage

>>> rtl/core/source_byte_tokenizer.sv
`timescale 1ns / 1ps

// Maximal-munch tokenizer that takes one source byte per cycle unless in_stall is raised.
// An accepted byte sits in an input register, where the lexer logic turns it into zero,
// one or two tokens that go into a four-entry result queue, and the first token of a byte
// is offered from the head of that queue. A new byte is taken every cycle as long as the
// queue has room for two tokens; since the output side moves one token per cycle while
// out_stall is low, a byte that closes a held token and opens another single-byte token
// puts two tokens in the queue. An unknown byte yields an error token and the block then
// drops all further bytes without result until reset.
module source_byte_tokenizer import sbt_pkg::*; #(
  parameter int LENGTH_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_source_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_token_kind,
  output logic [31:0] out_start_position,
  output logic [15:0] out_token_length,
  output logic        out_last_of_step
);

  logic       stg_v_r, stg_v_nxt;
  logic [7:0] stg_byte_r;
  logic       stg_eoi_r;
  logic       room, adv, take;
  result_t    res0, res1, head;
  logic [1:0] res_cnt, push_cnt;

  assign adv      = stg_v_r && room;
  assign in_stall = stg_v_r && !room;
  assign take     = in_valid && !in_stall;
  assign push_cnt = adv ? res_cnt : 2'd0;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (take) begin
      stg_v_nxt = 1'b1;
    end else if (adv) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_byte_r <= in_source_byte;
      stg_eoi_r  <= in_end_of_input;
    end
  end

  sbt_lexer #(
    .LENGTH_BITS   (LENGTH_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .step_byte (stg_byte_r),
    .step_eoi  (stg_eoi_r),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  sbt_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (res0),
    .push1     (res1),
    .push_cnt  (push_cnt),
    .room      (room),
    .pop_valid (out_valid),
    .pop       (!out_stall),
    .head      (head)
  );

  assign out_token_kind     = head.kind;
  assign out_start_position = head.start;
  assign out_token_length   = head.len;
  assign out_last_of_step   = head.last;

endmodule

>>> rtl/core/sbt_lexer.sv
`timescale 1ns / 1ps

module sbt_lexer import sbt_pkg::*; #(
  parameter int LENGTH_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] step_byte,
  input  logic       step_eoi,
  output result_t    res0,
  output result_t    res1,
  output logic [1:0] res_cnt
);

  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  mode_t                    mode_r, mode_nxt;
  logic [3:0]               pend_r, pend_nxt;
  logic [1:0]               kwp_r, kwp_nxt;
  logic [POSITION_BITS-1:0] tstart_r, tstart_nxt;
  logic [LENGTH_BITS-1:0]   tcnt_r, tcnt_nxt;
  logic [POSITION_BITS-1:0] bpos_r, bpos_nxt;
  logic                     halted_r, halted_nxt;

  logic [LENGTH_BITS-1:0] tcnt_inc;
  logic [63:0]            tstart_w, bpos_w, tcnt_w, tcnt_inc_w;
  result_t                held, fst, snd;
  logic                   fst_v, snd_v, absorbed;

  assign tcnt_inc   = (tcnt_r == LEN_MAX) ? tcnt_r : tcnt_r + LEN_ONE;
  assign tstart_w   = 64'(tstart_r);
  assign bpos_w     = 64'(bpos_r);
  assign tcnt_w     = 64'(tcnt_r);
  assign tcnt_inc_w = 64'(tcnt_inc);

  always_comb begin
    held.start = tstart_w[31:0];
    held.len   = tcnt_w[15:0];
    held.last  = 1'b0;
    case (mode_r)
      MODE_WORD: held.kind = (kwp_r == 2'd2) ? K_FN : K_NAME;
      MODE_NUM:  held.kind = K_INT;
      MODE_OP:   held.kind = alone_kind(pend_r);
      default:   held.kind = K_END;
    endcase
  end

  always_comb begin
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    kwp_nxt    = kwp_r;
    tstart_nxt = tstart_r;
    tcnt_nxt   = tcnt_r;
    bpos_nxt   = bpos_r;
    halted_nxt = halted_r;
    fst_v      = 1'b0;
    snd_v      = 1'b0;
    fst        = held;
    snd        = '0;
    absorbed   = 1'b0;
    if (step && !halted_r) begin
      if (step_eoi) begin
        fst_v      = (mode_r != MODE_IDLE);
        snd_v      = 1'b1;
        snd.kind   = K_END;
        snd.start  = bpos_w[31:0];
        snd.len    = 16'd0;
        mode_nxt   = MODE_IDLE;
        pend_nxt   = P_NONE;
        kwp_nxt    = 2'd0;
        tcnt_nxt   = '0;
      end else begin
        bpos_nxt = bpos_r + POS_ONE;
        if (mode_r == MODE_WORD && is_word_byte(step_byte)) begin
          absorbed = 1'b1;
          kwp_nxt  = (kwp_r == 2'd1 && step_byte == CHAR_N) ? 2'd2 : 2'd3;
          tcnt_nxt = tcnt_inc;
        end else if (mode_r == MODE_NUM && is_digit_byte(step_byte)) begin
          absorbed = 1'b1;
          tcnt_nxt = tcnt_inc;
        end else if (mode_r == MODE_OP) begin
          snd.start = tstart_w[31:0];
          snd.len   = tcnt_inc_w[15:0];
          if (step_byte == "=" || (pend_r == P_AND && step_byte == "&") ||
              (pend_r == P_OR && step_byte == "|")) begin
            absorbed = 1'b1;
            snd_v    = 1'b1;
            if (step_byte == "=") begin
              snd.kind = eq_kind(pend_r);
            end else if (pend_r == P_AND) begin
              snd.kind = K_LAND;
            end else begin
              snd.kind = K_LOR;
            end
            mode_nxt = MODE_IDLE;
            pend_nxt = P_NONE;
            tcnt_nxt = '0;
          end else if (pend_r == P_LT && step_byte == "<") begin
            absorbed = 1'b1;
            pend_nxt = P_SHL;
            tcnt_nxt = tcnt_inc;
          end else if (pend_r == P_GT && step_byte == ">") begin
            absorbed = 1'b1;
            pend_nxt = P_SHR;
            tcnt_nxt = tcnt_inc;
          end
        end
        if (!absorbed) begin
          fst_v     = (mode_r != MODE_IDLE);
          mode_nxt  = MODE_IDLE;
          pend_nxt  = P_NONE;
          kwp_nxt   = 2'd0;
          tcnt_nxt  = '0;
          snd.start = bpos_w[31:0];
          snd.len   = 16'd1;
          snd.kind  = K_ERROR;
          case (step_byte)
            " ", "\t", "\r", "\n", 8'h00: snd_v = 1'b0;
            "(": begin snd_v = 1'b1; snd.kind = K_LPAREN;   end
            ")": begin snd_v = 1'b1; snd.kind = K_RPAREN;   end
            "{": begin snd_v = 1'b1; snd.kind = K_LBRACE;   end
            "}": begin snd_v = 1'b1; snd.kind = K_RBRACE;   end
            "[": begin snd_v = 1'b1; snd.kind = K_LBRACKET; end
            "]": begin snd_v = 1'b1; snd.kind = K_RBRACKET; end
            "~": begin snd_v = 1'b1; snd.kind = K_NOT;      end
            "+", "-", "*", "/", "%", "=", "&", "|", "^", "<", ">", "!": begin
              mode_nxt   = MODE_OP;
              tstart_nxt = bpos_r;
              tcnt_nxt   = LEN_ONE;
              case (step_byte)
                "+":     pend_nxt = P_ADD;
                "-":     pend_nxt = P_SUB;
                "*":     pend_nxt = P_MUL;
                "/":     pend_nxt = P_DIV;
                "%":     pend_nxt = P_MOD;
                "=":     pend_nxt = P_ASSIGN;
                "&":     pend_nxt = P_AND;
                "|":     pend_nxt = P_OR;
                "^":     pend_nxt = P_XOR;
                "<":     pend_nxt = P_LT;
                ">":     pend_nxt = P_GT;
                default: pend_nxt = P_LNOT;
              endcase
            end
            default: begin
              if (is_word_byte(step_byte)) begin
                mode_nxt   = MODE_WORD;
                kwp_nxt    = (step_byte == CHAR_F) ? 2'd1 : 2'd3;
                tstart_nxt = bpos_r;
                tcnt_nxt   = LEN_ONE;
              end else if (is_digit_byte(step_byte)) begin
                mode_nxt   = MODE_NUM;
                tstart_nxt = bpos_r;
                tcnt_nxt   = LEN_ONE;
              end else begin
                snd_v      = 1'b1;
                halted_nxt = 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    res0 = '0;
    res1 = '0;
    if (fst_v) begin
      res0      = fst;
      res0.last = !snd_v;
      res1      = snd;
      res1.last = 1'b1;
      res_cnt   = snd_v ? 2'd2 : 2'd1;
    end else begin
      res0      = snd;
      res0.last = 1'b1;
      res_cnt   = snd_v ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pend_r   <= P_NONE;
      kwp_r    <= 2'd0;
      tstart_r <= '0;
      tcnt_r   <= '0;
      bpos_r   <= '0;
      halted_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      kwp_r    <= kwp_nxt;
      tstart_r <= tstart_nxt;
      tcnt_r   <= tcnt_nxt;
      bpos_r   <= bpos_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

>>> rtl/core/sbt_res_fifo.sv
`timescale 1ns / 1ps

module sbt_res_fifo import sbt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  result_t    push0,
  input  result_t    push1,
  input  logic [1:0] push_cnt,
  output logic       room,
  output logic       pop_valid,
  input  logic       pop,
  output result_t    head
);

  localparam logic [RES_CNT_BITS-1:0] ROOM_MAX = RES_CNT_BITS'(RES_DEPTH - 2);
  localparam logic [RES_PTR_BITS-1:0] PTR_ONE  = RES_PTR_BITS'(1);

  result_t                 mem_r [RES_DEPTH];
  logic [RES_PTR_BITS-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [RES_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    do_pop;

  assign room      = (cnt_r <= ROOM_MAX);
  assign pop_valid = (cnt_r != '0);
  assign head      = mem_r[rptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wptr_nxt = wptr_r + RES_PTR_BITS'(push_cnt);
    rptr_nxt = do_pop ? rptr_r + PTR_ONE : rptr_r;
    cnt_nxt  = cnt_r + RES_CNT_BITS'(push_cnt) - RES_CNT_BITS'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wptr_r + PTR_ONE] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sbt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RANDOM_BYTES = 1200;
  localparam int unsigned LONG_RUN_BYTES = 90;
  localparam int unsigned REPORT_LIMIT = 40;

  localparam logic [7:0] CHR_NUL = 8'h00;
  localparam logic [7:0] CHR_TAB = 8'h09;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_CR  = 8'h0D;

  localparam logic [1:0] FN_NONE  = 2'd0;
  localparam logic [1:0] FN_F     = 2'd1;
  localparam logic [1:0] FN_FULL  = 2'd2;
  localparam logic [1:0] FN_OTHER = 2'd3;

  localparam int unsigned STALL_NONE     = 0;
  localparam int unsigned STALL_PERIODIC = 1;
  localparam int unsigned STALL_RANDOM   = 2;
  localparam int unsigned STALL_LONG     = 3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_source_byte = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_token_kind;
  logic [31:0] out_start_position;
  logic [15:0] out_token_length;
  logic        out_last_of_step;

  source_byte_tokenizer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_source_byte     (in_source_byte),
    .in_end_of_input    (in_end_of_input),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_kind     (out_token_kind),
    .out_start_position (out_start_position),
    .out_token_length   (out_token_length),
    .out_last_of_step   (out_last_of_step)
  );

  mode_t       lex_mode = MODE_IDLE;
  logic [3:0]  held_op = P_NONE;
  logic [1:0]  fn_match = FN_NONE;
  logic [31:0] held_start = '0;
  logic [15:0] held_len = '0;
  logic [31:0] next_offset = '0;
  bit          lex_halted = 1'b0;

  result_t     step_tokens[$];
  result_t     expected_tokens[$];

  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  bit          valid_high = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned hold_mode = STALL_NONE;
  int unsigned hold_left = 0;
  int unsigned hold_tick = 0;

  string op_spellings [0:36] = '{
    "(", ")", "{", "}", "[", "]", "~",
    "+", "+=", "-", "-=", "*", "*=", "/", "/=", "%", "%=",
    "=", "==", "&", "&&", "&=", "|", "||", "|=", "^", "^=",
    "<", "<<", "<<=", "<=", ">", ">>", ">>=", ">=", "!", "!="
  };

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit is_word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c[7];
  endfunction

  function automatic bit is_digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit lexable(input logic [7:0] c);
    return is_word_char(c) || is_digit_char(c) ||
           (c inside {" ", CHR_TAB, CHR_LF, CHR_CR, CHR_NUL, "(", ")", "{", "}", "[", "]",
                      "~", "+", "-", "*", "/", "%", "=", "&", "|", "^", "<", ">", "!"});
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] n);
    return (n == 16'hFFFF) ? n : n + 16'd1;
  endfunction

  function automatic logic [5:0] op_kind(input logic [3:0] p, input bit with_eq);
    logic [5:0] k;
    k = K_ERROR;
    case (p)
      P_ADD:    k = with_eq ? K_ADD_EQ : K_ADD;
      P_SUB:    k = with_eq ? K_SUB_EQ : K_SUB;
      P_MUL:    k = with_eq ? K_MUL_EQ : K_MUL;
      P_DIV:    k = with_eq ? K_DIV_EQ : K_DIV;
      P_MOD:    k = with_eq ? K_MOD_EQ : K_MOD;
      P_ASSIGN: k = with_eq ? K_EQ : K_ASSIGN;
      P_AND:    k = with_eq ? K_AND_EQ : K_AND;
      P_OR:     k = with_eq ? K_OR_EQ : K_OR;
      P_XOR:    k = with_eq ? K_XOR_EQ : K_XOR;
      P_LT:     k = with_eq ? K_LE : K_LT;
      P_SHL:    k = with_eq ? K_SHL_EQ : K_SHL;
      P_GT:     k = with_eq ? K_GE : K_GT;
      P_SHR:    k = with_eq ? K_SHR_EQ : K_SHR;
      P_LNOT:   k = with_eq ? K_NE : K_LNOT;
      default:  k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic void note_token(input logic [5:0] kind, input logic [31:0] start,
                                     input logic [15:0] len);
    result_t t;
    t.kind = kind;
    t.start = start;
    t.len = len;
    t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void close_held();
    case (lex_mode)
      MODE_WORD: note_token((fn_match == FN_FULL) ? K_FN : K_NAME, held_start, held_len);
      MODE_NUM:  note_token(K_INT, held_start, held_len);
      MODE_OP:   note_token(op_kind(held_op, 1'b0), held_start, held_len);
      default:   ;
    endcase
    lex_mode = MODE_IDLE;
    held_op = P_NONE;
    fn_match = FN_NONE;
    held_len = '0;
  endfunction

  function automatic void hold_op(input logic [3:0] p);
    lex_mode = MODE_OP;
    held_op = p;
    held_start = next_offset;
    held_len = 16'd1;
  endfunction

  function automatic void open_token(input logic [7:0] c);
    case (c)
      " ", CHR_TAB, CHR_CR, CHR_LF, CHR_NUL: ;
      "(": note_token(K_LPAREN, next_offset, 16'd1);
      ")": note_token(K_RPAREN, next_offset, 16'd1);
      "{": note_token(K_LBRACE, next_offset, 16'd1);
      "}": note_token(K_RBRACE, next_offset, 16'd1);
      "[": note_token(K_LBRACKET, next_offset, 16'd1);
      "]": note_token(K_RBRACKET, next_offset, 16'd1);
      "~": note_token(K_NOT, next_offset, 16'd1);
      "+": hold_op(P_ADD);
      "-": hold_op(P_SUB);
      "*": hold_op(P_MUL);
      "/": hold_op(P_DIV);
      "%": hold_op(P_MOD);
      "=": hold_op(P_ASSIGN);
      "&": hold_op(P_AND);
      "|": hold_op(P_OR);
      "^": hold_op(P_XOR);
      "<": hold_op(P_LT);
      ">": hold_op(P_GT);
      "!": hold_op(P_LNOT);
      default: begin
        if (is_word_char(c)) begin
          lex_mode = MODE_WORD;
          fn_match = (c == CHAR_F) ? FN_F : FN_OTHER;
          held_start = next_offset;
          held_len = 16'd1;
        end else if (is_digit_char(c)) begin
          lex_mode = MODE_NUM;
          held_start = next_offset;
          held_len = 16'd1;
        end else begin
          note_token(K_ERROR, next_offset, 16'd1);
          lex_halted = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic bit absorb_byte(input logic [7:0] c);
    if (lex_mode == MODE_WORD && is_word_char(c)) begin
      fn_match = (fn_match == FN_F && c == CHAR_N) ? FN_FULL : FN_OTHER;
      held_len = bump(held_len);
      return 1'b1;
    end
    if (lex_mode == MODE_NUM && is_digit_char(c)) begin
      held_len = bump(held_len);
      return 1'b1;
    end
    if (lex_mode != MODE_OP) return 1'b0;
    if (c == "=") begin
      note_token(op_kind(held_op, 1'b1), held_start, bump(held_len));
    end else if (held_op == P_AND && c == "&") begin
      note_token(K_LAND, held_start, bump(held_len));
    end else if (held_op == P_OR && c == "|") begin
      note_token(K_LOR, held_start, bump(held_len));
    end else if ((held_op == P_LT && c == "<") || (held_op == P_GT && c == ">")) begin
      held_op = (held_op == P_LT) ? P_SHL : P_SHR;
      held_len = bump(held_len);
      return 1'b1;
    end else begin
      return 1'b0;
    end
    lex_mode = MODE_IDLE;
    held_op = P_NONE;
    held_len = '0;
    return 1'b1;
  endfunction

  function automatic void lex_byte(input logic [7:0] c, input logic eoi);
    step_tokens.delete();
    if (lex_halted) return;
    if (eoi) begin
      close_held();
      note_token(K_END, next_offset, 16'd0);
    end else begin
      if (lex_mode == MODE_IDLE) begin
        open_token(c);
      end else if (!absorb_byte(c)) begin
        close_held();
        open_token(c);
      end
      next_offset = next_offset + 32'd1;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic logic [7:0] any_lexable_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (!lexable(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 4))
      0: return " ";
      1: return CHR_TAB;
      2: return CHR_CR;
      3: return CHR_LF;
      default: return CHR_NUL;
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    in_valid <= 1'b1;
    in_source_byte <= c;
    in_end_of_input <= eoi;
    valid_high = 1'b1;
    do @(posedge clk); while (in_stall);
    lex_byte(c, eoi);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 300) : $urandom_range(1, 20);
      in_valid <= 1'b0;
      valid_high = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic test_corner_text();
    send_text("fn f");
    send_byte(8'hFF, 1'b0);
    send_text("(09<<=!");
    send_byte(CHR_NUL, 1'b0);
    send_text("&&|=>>");
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(8'h80, 1'b0);
    send_text("zA~-");
    send_byte(CHR_NUL, 1'b1);
  endtask

  task automatic test_random_text();
    int unsigned target;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      case ($urandom_range(0, 99)) inside
        [0:29]: begin
          case ($urandom_range(0, 4))
            0: send_text("fn");
            1: send_text("f");
            2: begin
              send_text("fn");
              send_byte(word_char(), 1'b0);
            end
            default: repeat ($urandom_range(1, 8)) send_byte(word_char(), 1'b0);
          endcase
        end
        [30:44]: repeat ($urandom_range(1, 6)) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        [45:74]: send_text(op_spellings[$urandom_range(0, 36)]);
        [75:84]: send_byte(blank_char(), 1'b0);
        [85:92]: send_byte(any_lexable_byte(), 1'b0);
        default: send_byte(8'($urandom_range(0, 255)), 1'b1);
      endcase
      if ($urandom_range(0, 1) == 0) send_byte(blank_char(), 1'b0);
    end
  endtask

  task automatic test_long_tokens();
    repeat (LONG_RUN_BYTES) send_byte(word_char(), 1'b0);
    send_byte(blank_char(), 1'b0);
    repeat (LONG_RUN_BYTES) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_unknown_byte();
    logic [7:0] bad;
    bad = 8'($urandom_range(0, 255));
    while (lexable(bad)) bad = 8'($urandom_range(0, 255));
    send_text("ab");
    send_byte(bad, 1'b0);
    repeat (4) send_byte(any_lexable_byte(), 1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk) begin
    if (hold_left == 0) begin
      hold_mode = $urandom_range(STALL_NONE, STALL_LONG);
      hold_left = $urandom_range(20, 200);
    end
    hold_left--;
    hold_tick++;
    case (hold_mode)
      STALL_PERIODIC: out_stall <= (hold_tick % 3) == 0;
      STALL_RANDOM:   out_stall <= $urandom_range(0, 9) < 4;
      STALL_LONG:     out_stall <= (hold_tick % 16) < 10;
      default:        out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: token mismatch, expected none, actual kind %0d at %0d", $time,
                   out_token_kind, out_start_position);
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", 32'(want.kind), 32'(out_token_kind));
        check_field("start_position", want.start, out_start_position);
        check_field("token_length", 32'(want.len), 32'(out_token_length));
        check_field("last_of_step", 32'(want.last), 32'(out_last_of_step));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_text();
    test_random_text();
    test_long_tokens();
    test_unknown_byte();
    if (valid_high) in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sbt_pkg.sv
rtl/core/sbt_lexer.sv
rtl/core/sbt_res_fifo.sv
rtl/core/source_byte_tokenizer.sv
tb/testbench.sv
